// File: rtl/core/sctag_pkg.sv
// ----------------------------------------------------------------------------
// Sector cache tag controller package
// Sizes, function and disk command codes, and the control/status bundles
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package sctag_pkg;

   localparam int SLOTS       = 64;
   localparam int SECTOR_BITS = 32;
   localparam int SECTOR_W    = 32;
   localparam int SLOT_W      = 6;
   localparam int SLOT_BITS   = $clog2(SLOTS);
   localparam int CNT_BITS    = $clog2(SLOTS + 1);

   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_FLUSH = 2'd2;

   localparam logic [1:0] DISK_NONE      = 2'd0;
   localparam logic [1:0] DISK_WRITEBACK = 2'd1;
   localparam logic [1:0] DISK_FILL      = 2'd2;

   typedef struct packed {
      logic capture;
      logic lk_step;
      logic vic_step;
      logic idx_clr;
      logic idx_inc;
      logic tag_rd;
      logic hit;
      logic fill_new;
      logic fill_vic;
      logic load_wb;
      logic wb_flush;
   } sctag_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       match;
      logic       scan_end;
      logic       rd_busy;
      logic       full;
      logic       used_cur;
      logic       dirty_cur;
      logic       out_last;
   } sctag_status_type;

endpackage

// File: rtl/core/sctag_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one access or flush transaction.
// ----------------------------------------------------------------------------
interface sctag_req_if import sctag_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          func;
   logic [SECTOR_W-1:0] sector;

   modport source (output valid, output func, output sector, input ready);
   modport sink (input valid, input func, input sector, output ready);
endinterface

// File: rtl/core/sctag_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result transaction of the tag controller.
// ----------------------------------------------------------------------------
interface sctag_rsp_if import sctag_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SLOT_W-1:0]   slot;
   logic                hit;
   logic [1:0]          disk_op;
   logic [SECTOR_W-1:0] disk_sector;
   logic                last;

   modport source (output valid, output slot, output hit, output disk_op,
                   output disk_sector, output last, input ready);
   modport sink (input valid, input slot, input hit, input disk_op,
                 input disk_sector, input last, output ready);
endinterface

// File: rtl/core/sctag_datapath.sv
// ----------------------------------------------------------------------------
// Sector cache tag datapath
// Tag memory, used and dirty bits, allocation count, scan index and the
// result register, all driven by controller commands.
// ----------------------------------------------------------------------------
module sctag_datapath import sctag_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  sctag_cmd_type       cmd,
   output sctag_status_type    status,
   input  logic [1:0]          req_func,
   input  logic [SECTOR_W-1:0] req_sector,
   output logic [SLOT_W-1:0]   out_slot,
   output logic                out_hit,
   output logic [1:0]          out_disk_op,
   output logic [SECTOR_W-1:0] out_disk_sector,
   output logic                out_last
);

   logic [SECTOR_BITS-1:0] tag_mem [SLOTS];

   logic [1:0]             func_ff, func_in;
   logic [SECTOR_BITS-1:0] sector_ff, sector_in;
   logic [CNT_BITS-1:0]    alloc_ff, alloc_in;
   logic [CNT_BITS-1:0]    idx_ff, idx_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [SLOT_BITS-1:0]   rd_slot_ff, rd_slot_in;
   logic [SECTOR_BITS-1:0] rd_tag_ff;
   logic [SLOTS-1:0]       used_ff, used_in;
   logic [SLOTS-1:0]       dirty_ff, dirty_in;
   logic [SLOT_W-1:0]      o_slot_ff, o_slot_in;
   logic                   o_hit_ff, o_hit_in;
   logic [1:0]             o_op_ff, o_op_in;
   logic [SECTOR_W-1:0]    o_sec_ff, o_sec_in;
   logic                   o_last_ff, o_last_in;

   logic [SLOT_BITS-1:0]   idx_slot;
   logic [SLOT_BITS-1:0]   alloc_slot;
   logic                   idx_lt;
   logic                   is_write;
   logic [SLOTS-1:0]       dirty_hi;
   logic                   dirty_above;
   logic                   mem_re;
   logic                   mem_we;
   logic [SLOT_BITS-1:0]   mem_waddr;

   assign idx_slot    = idx_ff[SLOT_BITS-1:0];
   assign alloc_slot  = alloc_ff[SLOT_BITS-1:0];
   assign idx_lt      = idx_ff < alloc_ff;
   assign is_write    = func_ff == FUNC_WRITE;
   assign dirty_hi    = dirty_ff >> idx_ff;
   assign dirty_above = |dirty_hi[SLOTS-1:1];
   assign mem_re      = (cmd.lk_step && idx_lt) || cmd.tag_rd;
   assign mem_we      = cmd.fill_new || cmd.fill_vic;
   assign mem_waddr   = cmd.fill_new ? alloc_slot : idx_slot;

   always_comb begin
      func_in    = func_ff;
      sector_in  = sector_ff;
      alloc_in   = alloc_ff;
      idx_in     = idx_ff;
      rd_vld_in  = cmd.lk_step && idx_lt;
      rd_slot_in = rd_slot_ff;
      used_in    = used_ff;
      dirty_in   = dirty_ff;
      o_slot_in  = o_slot_ff;
      o_hit_in   = o_hit_ff;
      o_op_in    = o_op_ff;
      o_sec_in   = o_sec_ff;
      o_last_in  = o_last_ff;

      if (cmd.capture) begin
         func_in   = req_func;
         sector_in = req_sector[SECTOR_BITS-1:0];
         idx_in    = '0;
      end
      if (cmd.lk_step && idx_lt) begin
         rd_slot_in = idx_slot;
         idx_in     = idx_ff + CNT_BITS'(1);
      end
      if (cmd.vic_step) begin
         used_in[idx_slot] = 1'b0;
         idx_in = (idx_slot == SLOT_BITS'(SLOTS - 1)) ? '0 : idx_ff + CNT_BITS'(1);
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + CNT_BITS'(1);
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
      end
      if (cmd.hit) begin
         used_in[rd_slot_ff] = 1'b1;
         if (is_write) begin
            dirty_in[rd_slot_ff] = 1'b1;
         end
         o_slot_in = SLOT_W'(rd_slot_ff);
         o_hit_in  = 1'b1;
         o_op_in   = DISK_NONE;
         o_sec_in  = SECTOR_W'(sector_ff);
         o_last_in = 1'b1;
      end
      if (cmd.fill_new || cmd.fill_vic) begin
         used_in[mem_waddr]  = 1'b1;
         dirty_in[mem_waddr] = is_write;
         o_slot_in = SLOT_W'(mem_waddr);
         o_hit_in  = 1'b0;
         o_op_in   = DISK_FILL;
         o_sec_in  = SECTOR_W'(sector_ff);
         o_last_in = 1'b1;
      end
      if (cmd.fill_new) begin
         alloc_in = alloc_ff + CNT_BITS'(1);
      end
      if (cmd.load_wb) begin
         dirty_in[idx_slot] = 1'b0;
         o_slot_in = SLOT_W'(idx_slot);
         o_hit_in  = 1'b0;
         o_op_in   = DISK_WRITEBACK;
         o_sec_in  = SECTOR_W'(rd_tag_ff);
         o_last_in = cmd.wb_flush && !dirty_above;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff  <= '0;
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
         used_ff   <= '0;
         dirty_ff  <= '0;
      end else begin
         alloc_ff  <= alloc_in;
         idx_ff    <= idx_in;
         rd_vld_ff <= rd_vld_in;
         used_ff   <= used_in;
         dirty_ff  <= dirty_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      sector_ff  <= sector_in;
      rd_slot_ff <= rd_slot_in;
      o_slot_ff  <= o_slot_in;
      o_hit_ff   <= o_hit_in;
      o_op_ff    <= o_op_in;
      o_sec_ff   <= o_sec_in;
      o_last_ff  <= o_last_in;
   end

   // Tag store with a separate write port and registered read port: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[mem_waddr] <= sector_ff;
      end
      if (mem_re) begin
         rd_tag_ff <= tag_mem[idx_slot];
      end
   end

   assign status.func      = func_ff;
   assign status.match     = rd_vld_ff && (rd_tag_ff == sector_ff);
   assign status.scan_end  = idx_ff == alloc_ff;
   assign status.rd_busy   = rd_vld_ff;
   assign status.full      = alloc_ff == CNT_BITS'(SLOTS);
   assign status.used_cur  = used_ff[idx_slot];
   assign status.dirty_cur = dirty_ff[idx_slot];
   assign status.out_last  = o_last_ff;

   assign out_slot        = o_slot_ff;
   assign out_hit         = o_hit_ff;
   assign out_disk_op     = o_op_ff;
   assign out_disk_sector = o_sec_ff;
   assign out_last        = o_last_ff;

endmodule

// File: rtl/core/sctag_ctrl.sv
// ----------------------------------------------------------------------------
// Sector cache tag controller
// State machine sequencing lookup, victim scan, fill and flush.
// ----------------------------------------------------------------------------
module sctag_ctrl import sctag_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  sctag_status_type status,
   output sctag_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DECODE   = 4'd1;
   localparam logic [3:0] ST_LOOKUP   = 4'd2;
   localparam logic [3:0] ST_VICTIM   = 4'd3;
   localparam logic [3:0] ST_VIC_LOAD = 4'd4;
   localparam logic [3:0] ST_OUT_WB   = 4'd5;
   localparam logic [3:0] ST_FILL     = 4'd6;
   localparam logic [3:0] ST_OUT_LAST = 4'd7;
   localparam logic [3:0] ST_FLUSH    = 4'd8;
   localparam logic [3:0] ST_FL_LOAD  = 4'd9;
   localparam logic [3:0] ST_OUT_FL   = 4'd10;

   logic [3:0] state_ff, state_in;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = (state_ff == ST_OUT_WB) || (state_ff == ST_OUT_LAST)
                      || (state_ff == ST_OUT_FL);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.func)
               FUNC_READ, FUNC_WRITE: state_in = ST_LOOKUP;
               FUNC_FLUSH:            state_in = ST_FLUSH;
               default:               state_in = ST_IDLE;
            endcase
         end
         ST_LOOKUP: begin
            if (status.match) begin
               cmd.hit  = 1'b1;
               state_in = ST_OUT_LAST;
            end else if (status.scan_end && !status.rd_busy) begin
               if (!status.full) begin
                  cmd.fill_new = 1'b1;
                  state_in     = ST_OUT_LAST;
               end else begin
                  cmd.idx_clr = 1'b1;
                  state_in    = ST_VICTIM;
               end
            end else begin
               cmd.lk_step = 1'b1;
            end
         end
         ST_VICTIM: begin
            if (status.used_cur) begin
               cmd.vic_step = 1'b1;
            end else if (status.dirty_cur) begin
               cmd.tag_rd = 1'b1;
               state_in   = ST_VIC_LOAD;
            end else begin
               state_in = ST_FILL;
            end
         end
         ST_VIC_LOAD: begin
            cmd.load_wb = 1'b1;
            state_in    = ST_OUT_WB;
         end
         ST_OUT_WB: begin
            if (rsp_ready) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill_vic = 1'b1;
            state_in     = ST_OUT_LAST;
         end
         ST_OUT_LAST: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (status.scan_end) begin
               state_in = ST_IDLE;
            end else if (status.dirty_cur) begin
               cmd.tag_rd = 1'b1;
               state_in   = ST_FL_LOAD;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_FL_LOAD: begin
            cmd.load_wb  = 1'b1;
            cmd.wb_flush = 1'b1;
            state_in     = ST_OUT_FL;
         end
         ST_OUT_FL: begin
            if (rsp_ready) begin
               cmd.idx_inc = 1'b1;
               state_in    = status.out_last ? ST_IDLE : ST_FLUSH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/sector_cache_second_chance_tags_core.sv
// ----------------------------------------------------------------------------
// Sector cache second-chance tag controller
// Fully associative write-back tag and replacement control for a sector cache.
// ----------------------------------------------------------------------------
// A hit ends the lookup at the matching slot; a miss first reads every allocated slot.
// A full-cache miss adds the second-chance scan and the fill, plus a write-back
// when the victim is dirty. A flush steps through every allocated slot and writes
// back each dirty one. Throughput: one transaction in work at a time.
// Synchronous reset clears used, dirty and allocation state; tags are not cleared.
module sector_cache_second_chance_tags_core import sctag_pkg::*; (
   input logic clock,
   input logic reset,
   sctag_req_if.sink   req_chan,
   sctag_rsp_if.source rsp_chan
);

   // The controller sequences each transaction; the datapath holds all state,
   // including the tag memory, which lookup scans one slot per cycle through its
   // single registered read port. That port sets the pace of lookup.
   sctag_cmd_type    cmd;
   sctag_status_type status;

   sctag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The result register lives in the datapath and is loaded only when the
   // controller moves into a state that presents it, so it holds steady while
   // the response side stalls.
   sctag_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_chan.func),
      .req_sector      (req_chan.sector),
      .out_slot        (rsp_chan.slot),
      .out_hit         (rsp_chan.hit),
      .out_disk_op     (rsp_chan.disk_op),
      .out_disk_sector (rsp_chan.disk_sector),
      .out_last        (rsp_chan.last)
   );

`ifndef SYNTHESIS
   // A new transaction is never taken while a result is still pending.
   a_no_accept_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("request ready while a response is pending");

   // The block is not ready in the cycle after it accepts a transaction.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request accepted on consecutive cycles");

   // A fill or a hit always closes its transaction.
   a_fill_hit_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.hit || rsp_chan.disk_op == DISK_FILL)
      |-> rsp_chan.last)
      else $error("fill or hit response without last");

   // A hit never carries a disk command.
   a_hit_no_disk: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.hit |-> rsp_chan.disk_op == DISK_NONE)
      else $error("hit response with disk command");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector cache second-chance tag controller testbench
// Drives read, write, flush and undefined transactions into the controller and
// checks every result transaction against a cycle-free behavioral predictor
// of the tag, used, dirty and allocation state, under several idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import sctag_pkg::*;

   // Function code that the controller must ignore without any result.
   localparam logic [1:0] FUNC_UNDEFINED = 2'd3;

   // Cycles with no transaction on either channel before the run is abandoned.
   // The slowest correct item is a full-cache miss (the lookup, the second-chance
   // scan and a write-back); the long receiver hold-off is HOLD_OFF_CYCLES.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int TAIL_CYCLES = 300;
   localparam int WORKING_SET = 96;

   typedef struct {
      logic [SLOT_W-1:0]   slot;
      logic                hit;
      logic [1:0]          disk_op;
      logic [SECTOR_W-1:0] disk_sector;
      logic                last;
   } cache_result_type;

   logic clock;
   logic reset;

   sctag_req_if req_chan ();
   sctag_rsp_if rsp_chan ();

   sector_cache_second_chance_tags_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predicted cache state. Tags of slots that were never allocated are never
   // compared, so they need no reset value.
   logic [SECTOR_W-1:0] tag_store [SLOTS];
   bit                  used_bit [SLOTS];
   bit                  dirty_bit [SLOTS];
   int unsigned         slots_filled = 0;

   // Results that the predictor expects, oldest first.
   cache_result_type pending_results[$];
   int               mismatches = 0;

   // Idle percentages for the current phase.
   int unsigned send_idle_pct = 0;
   int unsigned rcv_stall_pct = 0;

   // A hold-off request is posted by bumping hold_seq; the receiver process
   // picks it up and counts the cycles down itself.
   int unsigned hold_seq = 0;
   int unsigned hold_ack = 0;
   int unsigned hold_left = 0;

   int unsigned quiet_cycles = 0;

   // Sectors that random traffic returns to. There are more of them than
   // slots, so a full cache both hits and has to pick victims.
   logic [SECTOR_W-1:0] hot_sectors [WORKING_SET];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------
   function automatic void push_result(int unsigned slot, logic hit, logic [1:0] op,
                                       logic [SECTOR_W-1:0] sec, logic last);
      cache_result_type r;
      r.slot        = slot[SLOT_W-1:0];
      r.hit         = hit;
      r.disk_op     = op;
      r.disk_sector = sec;
      r.last        = last;
      pending_results.push_back(r);
   endfunction

   // Updates the cache state for one accepted transaction and queues the
   // results that the controller has to produce for it.
   function automatic void predict_cache_access(logic [1:0] func,
                                                logic [SECTOR_W-1:0] sector);
      logic [SECTOR_W-1:0] sec;
      int unsigned         i;
      int unsigned         serving;
      int unsigned         victim;
      int unsigned         dirty_count;
      int unsigned         sent;
      bit                  found;
      sec         = sector & SECTOR_W'((64'd1 << SECTOR_BITS) - 64'd1);
      found       = 1'b0;
      serving     = 0;
      dirty_count = 0;
      sent        = 0;

      if (func == FUNC_FLUSH) begin
         // Every dirty slot is written back in slot order; only the final
         // write-back carries last. No dirty slot means no result at all.
         for (i = 0; i < slots_filled; i++)
            if (dirty_bit[i])
               dirty_count++;
         for (i = 0; i < slots_filled; i++) begin
            if (dirty_bit[i]) begin
               sent++;
               push_result(i, 1'b0, DISK_WRITEBACK, tag_store[i], sent == dirty_count);
               dirty_bit[i] = 1'b0;
            end
         end
         return;
      end
      if (func == FUNC_UNDEFINED)
         return;

      for (i = 0; i < slots_filled && !found; i++) begin
         if (tag_store[i] == sec) begin
            found   = 1'b1;
            serving = i;
         end
      end

      if (found) begin
         used_bit[serving] = 1'b1;
         push_result(serving, 1'b1, DISK_NONE, sec, 1'b1);
      end else begin
         if (slots_filled < SLOTS) begin
            victim = slots_filled;
            slots_filled++;
         end else begin
            // Second chance: the first pass may only clear used bits, the
            // second pass then always finds a victim.
            victim = 0;
            for (int pass = 0; pass < 2 && !found; pass++) begin
               for (i = 0; i < SLOTS && !found; i++) begin
                  if (used_bit[i]) begin
                     used_bit[i] = 1'b0;
                  end else begin
                     victim = i;
                     found  = 1'b1;
                  end
               end
            end
            if (dirty_bit[victim])
               push_result(victim, 1'b0, DISK_WRITEBACK, tag_store[victim], 1'b0);
         end
         tag_store[victim] = sec;
         used_bit[victim]  = 1'b1;
         dirty_bit[victim] = 1'b0;
         push_result(victim, 1'b0, DISK_FILL, sec, 1'b1);
         serving = victim;
      end

      if (func == FUNC_WRITE)
         dirty_bit[serving] = 1'b1;
   endfunction

   // -------------------------------------------------------------------------
   // Result checking
   // -------------------------------------------------------------------------
   function automatic void check_field(string name, logic [SECTOR_W-1:0] want,
                                       logic [SECTOR_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Every result transaction is compared with the oldest expectation. Values
   // are read right after the edge, before this edge's updates land.
   always @(posedge clock) begin
      cache_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $error("result transaction with nothing expected: slot 0x%0h, op 0x%0h",
                   rsp_chan.slot, rsp_chan.disk_op);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("slot", SECTOR_W'(want.slot), SECTOR_W'(rsp_chan.slot));
            check_field("hit", SECTOR_W'(want.hit), SECTOR_W'(rsp_chan.hit));
            check_field("disk_op", SECTOR_W'(want.disk_op), SECTOR_W'(rsp_chan.disk_op));
            check_field("disk_sector", want.disk_sector, rsp_chan.disk_sector);
            check_field("last", SECTOR_W'(want.last), SECTOR_W'(rsp_chan.last));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random stalls at the phase's rate, or a counted hold-off.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_seq != hold_ack) begin
         hold_left = HOLD_OFF_CYCLES;
         hold_ack  = hold_seq;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
   end

   // The watchdog restarts on every transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender
   // -------------------------------------------------------------------------
   // Offers one transaction and returns at the edge where it is accepted.
   // Valid is left high, so back-to-back calls keep it asserted; it is only
   // lowered when an idle cycle is inserted or when the sender drains.
   task automatic send_request(input logic [1:0] func, input logic [SECTOR_W-1:0] sector);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         req_chan.func  <= 2'($urandom);
         req_chan.sector <= $urandom;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.func   <= func;
      req_chan.sector <= sector;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      predict_cache_access(func, sector);
   endtask

   // Mostly reads and writes on the hot set, some fresh sectors, an
   // occasional flush and a few undefined function codes.
   task automatic send_random_request();
      int unsigned         pick;
      logic [1:0]          func;
      logic [SECTOR_W-1:0] sector;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         func = FUNC_READ;
      else if (pick < 88)
         func = FUNC_WRITE;
      else if (pick < 96)
         func = FUNC_FLUSH;
      else
         func = FUNC_UNDEFINED;
      if ($urandom_range(0, 99) < 85)
         sector = hot_sectors[$urandom_range(0, WORKING_SET - 1)];
      else
         sector = $urandom;
      send_request(func, sector);
   endtask

   // Stops offering and waits until every expected result has arrived.
   task automatic wait_until_drained();
      req_chan.valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_results.size() != 0);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   // Hits, fills into free slots, write marking, flush with and without dirty
   // slots, the ignored function code and the sector extremes.
   task automatic test_directed();
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      send_request(FUNC_READ, 32'h0000_0000);
      send_request(FUNC_READ, 32'h0000_0000);
      send_request(FUNC_WRITE, 32'hFFFF_FFFF);
      send_request(FUNC_WRITE, 32'h0000_0000);
      send_request(FUNC_READ, 32'hFFFF_FFFF);
      send_request(FUNC_FLUSH, 32'h0000_0000);
      send_request(FUNC_FLUSH, 32'hFFFF_FFFF);
      send_request(FUNC_UNDEFINED, 32'h0000_1234);
      send_request(FUNC_WRITE, 32'h8000_0000);
      send_request(FUNC_WRITE, 32'h0000_0001);
      send_request(FUNC_READ, 32'h7FFF_FFFF);
      send_request(FUNC_WRITE, 32'hAAAA_AAAA);
      send_request(FUNC_READ, 32'h5555_5555);
      send_request(FUNC_WRITE, 32'h8000_0000);
      send_request(FUNC_UNDEFINED, 32'hFFFF_FFFF);
      send_request(FUNC_FLUSH, 32'h0000_0000);
      wait_until_drained();
   endtask

   // Fills every slot with distinct sectors, then keeps missing so that the
   // second-chance scan runs on a full cache, with both clean and dirty
   // victims, including the case where every used bit is set.
   task automatic test_fill_and_evict();
      logic [SECTOR_W-1:0] base;
      logic [SECTOR_W-1:0] stride;
      logic [SECTOR_W-1:0] filled [70];
      logic [1:0]          func;
      base   = $urandom;
      stride = $urandom | 32'd1;
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      for (int k = 0; k < 70; k++) begin
         filled[k] = base + stride * k;
         func = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
         send_request(func, filled[k]);
      end
      for (int k = 0; k < 40; k++) begin
         func = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
         if ($urandom_range(0, 1))
            send_request(func, filled[$urandom_range(0, 69)]);
         else
            send_request(func, $urandom);
      end
      wait_until_drained();
   endtask

   task automatic test_random_traffic(input int unsigned count, input int unsigned send_pct,
                                      input int unsigned rcv_pct);
      send_idle_pct = send_pct;
      rcv_stall_pct = rcv_pct;
      repeat (count)
         send_random_request();
      wait_until_drained();
   endtask

   // The receiver stops for a long stretch while the sender keeps offering,
   // so results back up and the controller has to stall its request side.
   task automatic test_back_pressure();
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      hold_seq++;
      repeat (20)
         send_random_request();
      wait_until_drained();
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.func   = FUNC_READ;
      req_chan.sector = '0;
      for (int k = 0; k < WORKING_SET; k++)
         hot_sectors[k] = $urandom;
      hot_sectors[0] = 32'h0000_0000;
      hot_sectors[1] = 32'hFFFF_FFFF;

      repeat (3)
         @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_fill_and_evict();
      test_random_traffic(80, 0, 0);
      test_random_traffic(80, 71, 0);
      test_random_traffic(80, 0, 71);
      test_random_traffic(80, 8, 8);
      test_back_pressure();

      // Give a late or extra result time to show up before the verdict.
      repeat (TAIL_CYCLES)
         @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/sctag_pkg.sv
rtl/core/sctag_req_if.sv
rtl/core/sctag_rsp_if.sv
rtl/core/sctag_datapath.sv
rtl/core/sctag_ctrl.sv
rtl/core/sector_cache_second_chance_tags_core.sv
tb/tb_top.sv
